/* src/assert_macros.svh */
// Assertion macros shared by the sliding window median RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/swm_pkg.sv */
// Package with shared types and constants of the sliding window median core.
package swm_pkg;

  localparam int WINDOW_LENGTH_DEFAULT = 11;
  localparam int TS_W                  = 32;
  localparam int CNT_PORT_W            = 5;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CAND,
    ST_SCAN,
    ST_TAIL,
    ST_JUDGE,
    ST_FINISH
  } swm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // an input beat is accepted this cycle
    logic start;    // restart the candidate index
    logic cand_rd;  // read the current candidate, reset scan index and counts
    logic scan;     // read the next window entry and count the previous one
    logic tail;     // count the last window entry
    logic judge;    // test the rank of the candidate and step to the next one
    logic finish;   // load the output register
  } swm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic j_last;
    logic i_last;
    logic hit;
    logic out_free;
  } swm_status_t;

endpackage

/* src/swm_ctrl.sv */
// Controller state machine that sequences the rank search of the median core.
module swm_ctrl import swm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  swm_status_t status,
  output swm_cmd_t    cmd
);

  swm_state_t state;
  swm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.start  = 1'b1;
        state_next = status.full ? ST_CAND : ST_FINISH;
      end
      ST_CAND: begin
        cmd.cand_rd = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.j_last) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = (status.hit || status.i_last) ? ST_FINISH : ST_CAND;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/swm_datapath.sv */
// Datapath of the median core: timestamp ring, counters, rank counting and output register.
module swm_datapath import swm_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  swm_cmd_t              cmd,
  output swm_status_t           status,
  input  logic                  kind,
  input  logic [TS_W-1:0]       timestamp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TS_W-1:0]       median_time,
  output logic [TS_W-1:0]       earliest_allowed,
  output logic                  window_full,
  output logic [CNT_PORT_W-1:0] filled_count
);

  localparam int AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CW = $clog2(WINDOW_LENGTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_LENGTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW_LENGTH);
  localparam logic [CW-1:0] WANT     = CW'(WINDOW_LENGTH / 2);

  logic [TS_W-1:0] ring [WINDOW_LENGTH];
  logic [TS_W-1:0] rd_q;
  logic [AW-1:0]   rd_addr;

  logic [AW-1:0]   write_slot;
  logic [CW-1:0]   fill_level;
  logic [AW-1:0]   cand_idx;
  logic [AW-1:0]   scan_idx;
  logic [TS_W-1:0] cand;
  logic [TS_W-1:0] med;
  logic [CW-1:0]   below;
  logic [CW-1:0]   at_or_below;
  logic            count_en;
  logic            full;

  assign full     = (fill_level == FULL_CNT);
  assign rd_addr  = cmd.cand_rd ? cand_idx : scan_idx;
  // The first scan cycle delivers the candidate itself; later ones deliver entries.
  assign count_en = (cmd.scan && (scan_idx != '0)) || cmd.tail;

  assign status.full     = full;
  assign status.j_last   = (scan_idx == LAST_IDX);
  assign status.i_last   = (cand_idx == LAST_IDX);
  assign status.hit      = (below <= WANT) && (WANT < at_or_below);
  assign status.out_free = !out_valid || !out_stall;

  // Ring storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.take && (kind == KIND_PUSH)) begin
      ring[write_slot] <= timestamp;
    end
    rd_q <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_level <= '0;
    end else if (cmd.take) begin
      if (kind == KIND_CLEAR) begin
        write_slot <= '0;
        fill_level <= '0;
      end else begin
        write_slot <= (write_slot == LAST_IDX) ? '0 : write_slot + AW'(1);
        if (fill_level != FULL_CNT) begin
          fill_level <= fill_level + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_idx <= '0;
      scan_idx <= '0;
    end else begin
      if (cmd.start) begin
        cand_idx <= '0;
      end else if (cmd.judge && !status.i_last) begin
        cand_idx <= cand_idx + AW'(1);
      end
      if (cmd.cand_rd) begin
        scan_idx <= '0;
      end else if (cmd.scan && !status.j_last) begin
        scan_idx <= scan_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_rd) begin
      below       <= '0;
      at_or_below <= '0;
    end else if (count_en) begin
      if (rd_q < cand) begin
        below <= below + CW'(1);
      end
      if (rd_q <= cand) begin
        at_or_below <= at_or_below + CW'(1);
      end
    end
    if (cmd.scan && (scan_idx == '0)) begin
      cand <= rd_q;
    end
    if (cmd.judge && status.hit) begin
      med <= cand;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      median_time      <= full ? med : '0;
      earliest_allowed <= full ? med + TS_W'(1) : '0;
      window_full      <= full;
      filled_count     <= CNT_PORT_W'(fill_level);
    end
  end

endmodule

/* src/sliding_window_median_core.sv */
// Top level of the sliding window median core.
`include "assert_macros.svh"

// The core keeps the last WINDOW_LENGTH 32-bit timestamps in a ring and
// answers every input beat with one result beat. A push beat (kind 0) writes
// the timestamp over the oldest entry; a clear beat (kind 1) empties the
// window. Each result carries the fill count and the full flag, and once the
// window is full the median (the entry of rank WINDOW_LENGTH/2 in ascending
// order, duplicates counted one by one) together with the median plus one,
// which wraps to 0 for an all-ones median. While the window is not full both
// median outputs read 0. A beat that leaves the window not full goes from the
// check state straight to the finish state. With a full window the median is
// found by rank counting: every candidate entry is read once and then
// compared against all WINDOW_LENGTH entries through the single read port of
// the ring; the search stops at the first candidate that has the median rank.
// The core takes one item at a time; a finished result waits in the output
// register while the next input beat is accepted. Ring entries are not
// cleared by reset or by a clear beat: the median is only computed when the
// fill count has reached the window length, and by then every entry has been
// rewritten.
module sliding_window_median_core import swm_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [TS_W-1:0]       timestamp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TS_W-1:0]       median_time,
  output logic [TS_W-1:0]       earliest_allowed,
  output logic                  window_full,
  output logic [CNT_PORT_W-1:0] filled_count
);

  swm_cmd_t    cmd;
  swm_status_t status;

  // The controller walks through candidates; it never touches data.
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the ring, the rank counters and the result register.
  swm_datapath #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .kind             (kind),
    .timestamp        (timestamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .median_time      (median_time),
    .earliest_allowed (earliest_allowed),
    .window_full      (window_full),
    .filled_count     (filled_count)
  );

  // A presented result never reports a fill count above the window length.
  `ASSERT_ALWAYS(a_fill_bound, !out_valid || (filled_count <= CNT_PORT_W'(WINDOW_LENGTH)), "fill count above window length")

  // A result from a window that is not full carries zero medians.
  `ASSERT_IMPL(a_zero_when_partial, out_valid && !window_full, (median_time == '0) && (earliest_allowed == '0), "nonzero median from partial window")

  // The second median output is always the first plus one when full.
  `ASSERT_IMPL(a_plus_one, out_valid && window_full, earliest_allowed == median_time + TS_W'(1), "earliest_allowed is not median plus one")

  // After an input beat is taken the core stalls its input in the next cycle.
  `ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input accepted twice in a row")

endmodule
